FILE: rtl/r2fft_pkg.sv
// Shared constants, types and twiddle table for the radix-2 FFT unit.
package r2fft_pkg;

  localparam int unsigned MAX_POINTS_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned VAL_BITS        = 22;
  localparam int unsigned TW_BITS         = 16;
  localparam int unsigned ROM_LOG         = 6;
  localparam int unsigned CNT_BITS        = 7;
  localparam int unsigned CFG_IDX_BITS    = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INVERSE     = 2'd1;

  localparam logic signed [VAL_BITS-1:0] VAL_MAX = {1'b0, {(VAL_BITS-1){1'b1}}};
  localparam logic signed [VAL_BITS-1:0] VAL_MIN = {1'b1, {(VAL_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_LOAD, ST_PAD, ST_RDA, ST_RDB, ST_MUL, ST_ADD, ST_WRA, ST_WRB, ST_ORD, ST_OUT
  } fft_state_e;

  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic inv;
  } bfly_ctl_t;

  // Quarter-wave cosine, Q1.15, entries 0..16.
  function automatic logic signed [TW_BITS-1:0] quarter_cos(input logic [4:0] k);
    logic signed [TW_BITS-1:0] r;
    unique case (k)
      5'd0:  r = 16'sd32767;
      5'd1:  r = 16'sd32610;
      5'd2:  r = 16'sd32138;
      5'd3:  r = 16'sd31357;
      5'd4:  r = 16'sd30274;
      5'd5:  r = 16'sd28899;
      5'd6:  r = 16'sd27246;
      5'd7:  r = 16'sd25330;
      5'd8:  r = 16'sd23170;
      5'd9:  r = 16'sd20788;
      5'd10: r = 16'sd18205;
      5'd11: r = 16'sd15447;
      5'd12: r = 16'sd12540;
      5'd13: r = 16'sd9512;
      5'd14: r = 16'sd6393;
      5'd15: r = 16'sd3212;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

  // Full-wave cosine over 64 steps built from the quarter table.
  function automatic logic signed [TW_BITS-1:0] rom_cos(input logic [ROM_LOG-1:0] k);
    logic signed [TW_BITS-1:0] r;
    if (k <= 6'd16)      r = quarter_cos(5'(k));
    else if (k <= 6'd32) r = -quarter_cos(5'(6'd32 - k));
    else if (k <= 6'd48) r = -quarter_cos(5'(k - 6'd32));
    else                 r = quarter_cos(5'(7'd64 - {1'b0, k}));
    return r;
  endfunction

  // Smallest l with 2^l >= c, for 1 <= c <= 64.
  function automatic logic [2:0] ceil_log2(input logic [CNT_BITS-1:0] c);
    logic [2:0] l;
    l = 3'd0;
    for (int i = 6; i >= 1; i--) begin
      if ({1'b0, c} > (8'd1 << (i - 1)) && l == 3'd0) l = 3'(i);
    end
    return l;
  endfunction

endpackage

FILE: rtl/r2fft_bfly.sv
// Shared complex butterfly: multiply stage, then add, round and saturate stage.
module r2fft_bfly (
  input  logic                                  clk_i,
  input  r2fft_pkg::bfly_ctl_t                  ctl_i,
  input  logic signed [r2fft_pkg::VAL_BITS-1:0] u_re_i,
  input  logic signed [r2fft_pkg::VAL_BITS-1:0] u_im_i,
  input  logic signed [r2fft_pkg::VAL_BITS-1:0] b_re_i,
  input  logic signed [r2fft_pkg::VAL_BITS-1:0] b_im_i,
  input  logic signed [r2fft_pkg::TW_BITS-1:0]  w_re_i,
  input  logic signed [r2fft_pkg::TW_BITS-1:0]  w_im_i,
  output logic signed [r2fft_pkg::VAL_BITS-1:0] s0_re_o,
  output logic signed [r2fft_pkg::VAL_BITS-1:0] s0_im_o,
  output logic signed [r2fft_pkg::VAL_BITS-1:0] s1_re_o,
  output logic signed [r2fft_pkg::VAL_BITS-1:0] s1_im_o
);
  import r2fft_pkg::*;

  localparam int unsigned PW = VAL_BITS + TW_BITS;
  localparam int unsigned XW = PW + 2;

  logic signed [PW-1:0]       p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [VAL_BITS-1:0] u_re_q, u_im_q;
  logic signed [TW_BITS-1:0]  w_im;
  logic signed [XW-1:0]       t_re, t_im;
  logic signed [XW-1:0]       s0_re, s0_im, s1_re, s1_im;

  function automatic logic signed [VAL_BITS-1:0] fin(input logic signed [XW-1:0] v,
                                                     input logic inv);
    logic signed [XW-1:0] h;
    h = inv ? v : ((v + XW'(1)) >>> 1);
    if (h > XW'(VAL_MAX))      return VAL_MAX;
    else if (h < XW'(VAL_MIN)) return VAL_MIN;
    else                       return h[VAL_BITS-1:0];
  endfunction

  assign w_im = ctl_i.inv ? -w_im_i : w_im_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      p_rr_q <= b_re_i * w_re_i;
      p_ii_q <= b_im_i * w_im;
      p_ri_q <= b_re_i * w_im;
      p_ir_q <= b_im_i * w_re_i;
      u_re_q <= u_re_i;
      u_im_q <= u_im_i;
    end
  end

  always_comb begin
    t_re  = (XW'(p_rr_q) - XW'(p_ii_q) + XW'(16384)) >>> 15;
    t_im  = (XW'(p_ri_q) + XW'(p_ir_q) + XW'(16384)) >>> 15;
    s0_re = XW'(u_re_q) + t_re;
    s0_im = XW'(u_im_q) + t_im;
    s1_re = XW'(u_re_q) - t_re;
    s1_im = XW'(u_im_q) - t_im;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.add_en) begin
      s0_re_o <= fin(s0_re, ctl_i.inv);
      s0_im_o <= fin(s0_im, ctl_i.inv);
      s1_re_o <= fin(s1_re, ctl_i.inv);
      s1_im_o <= fin(s1_im, ctl_i.inv);
    end
  end

endmodule

FILE: rtl/radix2_complex_fft_unit.sv
// Top level of the radix-2 decimation-in-time FFT: work memory, sequencer, output register.
//
// Usage: write point_count (index 0) and inverse (index 1) through cfg_we_i while idle;
// a write to either register drops a partially loaded transform. Then send point_count
// sample requests on the sample channel (valid/stall). Each sample lands in the work
// memory at its bit-reversed address. sample_stall_o is high whenever the unit is not loading.
// After the last sample the unit zeroes padding entries (one per cycle, N - point_count
// entries, N the next power of two), then runs (N/2)*log2(N) butterflies on one shared
// butterfly unit. Each butterfly reads its two operands from the work memory, passes the
// multiply and add stages of the unit, then writes its two results back.
// Bins 0..point_count-1 then leave on the bin channel, each read from the work memory
// before it is loaded into the output register, last_bin_o marking the final one.
// When the receiver stalls, the output register holds its bin and the unit waits.
// Reset (rst_ni low) returns to loading with point_count 64 and forward direction.
module radix2_complex_fft_unit #(
  parameter int unsigned MAX_POINTS  = r2fft_pkg::MAX_POINTS_DEF,
  parameter int unsigned SAMPLE_BITS = r2fft_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [r2fft_pkg::CFG_IDX_BITS-1:0]        cfg_idx_i,
  input  logic [r2fft_pkg::CNT_BITS-1:0]            cfg_data_i,
  input  logic                                      sample_valid_i,
  output logic                                      sample_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]             sample_re_i,
  input  logic signed [SAMPLE_BITS-1:0]             sample_im_i,
  output logic                                      bin_valid_o,
  input  logic                                      bin_stall_i,
  output logic signed [r2fft_pkg::VAL_BITS-1:0]     bin_re_o,
  output logic signed [r2fft_pkg::VAL_BITS-1:0]     bin_im_o,
  output logic                                      last_bin_o
);
  import r2fft_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned STW = $clog2(AW + 1);
  localparam int unsigned XW  = (SAMPLE_BITS > VAL_BITS) ? SAMPLE_BITS : VAL_BITS;

  // Configuration
  logic [CNT_BITS-1:0] point_count_q;
  logic                inverse_q;
  logic                cfg_hit;
  logic [CNT_BITS-1:0] cnt;
  logic [STW-1:0]      log_n;
  logic [CW-1:0]       n_pts;

  // Sequencer
  fft_state_e          state_q, state_d;
  logic [CNT_BITS-1:0] load_q;
  logic [CNT_BITS-1:0] idx_q;
  logic [STW-1:0]      st_q;
  logic [CW-1:0]       k_q, j_q;
  logic [CW-1:0]       half, m_pts;
  logic [AW-1:0]       addr_a, addr_b;
  logic                last_bfly, in_acc, out_load;

  // Memory
  logic [2*VAL_BITS-1:0] mem [MAX_POINTS];
  logic [2*VAL_BITS-1:0] rdata_q, wdata;
  logic [AW-1:0]         raddr, waddr;
  logic                  we;

  // Butterfly
  bfly_ctl_t                  bctl;
  logic signed [VAL_BITS-1:0] u_re_q, u_im_q;
  logic signed [VAL_BITS-1:0] s0_re, s0_im, s1_re, s1_im;
  logic signed [TW_BITS-1:0]  w_re, w_im;
  logic [11:0]                tw_full;
  logic [ROM_LOG-1:0]         tw_idx;

  // Output register
  logic                       bin_valid_q;
  logic signed [VAL_BITS-1:0] bin_re_q, bin_im_q;
  logic                       last_q;

  function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v, input logic [STW-1:0] l);
    logic [AW-1:0] r;
    for (int b = 0; b < AW; b++) r[AW-1-b] = v[b];
    return r >> (AW - l);
  endfunction

  function automatic logic signed [VAL_BITS-1:0] take(input logic signed [SAMPLE_BITS-1:0] s);
    logic signed [XW-1:0] x;
    x = XW'(s);
    if (x > XW'(VAL_MAX))      return VAL_MAX;
    else if (x < XW'(VAL_MIN)) return VAL_MIN;
    else                       return x[VAL_BITS-1:0];
  endfunction

  // Clamp the count: zero acts as one, large values as the memory depth.
  always_comb begin
    cnt = point_count_q;
    if (cnt == '0) cnt = CNT_BITS'(1);
    if (cnt > CNT_BITS'(MAX_POINTS)) cnt = CNT_BITS'(MAX_POINTS);
    log_n = STW'(ceil_log2(cnt));
    n_pts = CW'(1) << log_n;
  end

  // Only writes to an existing register drop a partial load.
  assign cfg_hit = cfg_we_i && (cfg_idx_i inside {REG_POINT_COUNT, REG_INVERSE});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= CNT_BITS'(64);
      inverse_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POINT_COUNT: point_count_q <= cfg_data_i;
        REG_INVERSE:     inverse_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Butterfly addressing for the current stage, group and offset.
  always_comb begin
    half      = CW'(1) << (st_q - STW'(1));
    m_pts     = half << 1;
    addr_a    = AW'(k_q + j_q);
    addr_b    = AW'(k_q + j_q + half);
    last_bfly = (j_q + CW'(1) == half) && (k_q + m_pts >= n_pts) && (st_q == log_n);
    tw_full   = 12'(j_q) << (ROM_LOG - 32'(st_q));
    tw_idx    = tw_full[ROM_LOG-1:0];
    w_re      = rom_cos(tw_idx);
    w_im      = rom_cos(tw_idx + ROM_LOG'(48));
  end

  assign in_acc   = (state_q == ST_LOAD) && sample_valid_i;
  assign out_load = (state_q == ST_OUT) && (!bin_valid_q || !bin_stall_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && load_q + CNT_BITS'(1) == cnt) begin
          if (CW'(cnt) != n_pts)     state_d = ST_PAD;
          else if (log_n == '0)      state_d = ST_ORD;
          else                       state_d = ST_RDA;
        end
      end
      ST_PAD: begin
        if (CW'(idx_q) + CW'(1) == n_pts) state_d = ST_RDA;
      end
      ST_RDA: state_d = ST_RDB;
      ST_RDB: state_d = ST_MUL;
      ST_MUL: state_d = ST_ADD;
      ST_ADD: state_d = ST_WRA;
      ST_WRA: state_d = ST_WRB;
      ST_WRB: state_d = last_bfly ? ST_ORD : ST_RDA;
      ST_ORD: state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) state_d = (idx_q + CNT_BITS'(1) == cnt) ? ST_LOAD : ST_ORD;
      end
      default: state_d = ST_LOAD;
    endcase
    if (cfg_hit) state_d = ST_LOAD;
  end

  // Outputs of the sequencer: memory ports and butterfly control
  always_comb begin
    we     = 1'b0;
    waddr  = addr_a;
    wdata  = {s0_re, s0_im};
    raddr  = addr_a;
    bctl   = '{mul_en: 1'b0, add_en: 1'b0, inv: inverse_q};
    unique case (state_q)
      ST_LOAD: begin
        we    = in_acc;
        waddr = bitrev(AW'(load_q), log_n);
        wdata = {take(sample_re_i), take(sample_im_i)};
      end
      ST_PAD: begin
        we    = 1'b1;
        waddr = bitrev(AW'(idx_q), log_n);
        wdata = '0;
      end
      ST_RDA: raddr = addr_a;
      ST_RDB: raddr = addr_b;
      ST_MUL: bctl.mul_en = 1'b1;
      ST_ADD: bctl.add_en = 1'b1;
      ST_WRA: we = 1'b1;
      ST_WRB: begin
        we    = 1'b1;
        waddr = addr_b;
        wdata = {s1_re, s1_im};
      end
      ST_ORD: raddr = AW'(idx_q);
      ST_OUT: raddr = AW'(idx_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      load_q  <= '0;
      idx_q   <= '0;
      st_q    <= STW'(1);
      k_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_hit) begin
        load_q <= '0;
      end else if (in_acc) begin
        // Last sample: start padding after the loaded count, or start the bins at zero.
        load_q <= (load_q + CNT_BITS'(1) == cnt) ? '0 : load_q + CNT_BITS'(1);
        idx_q  <= (load_q + CNT_BITS'(1) == cnt && CW'(cnt) != n_pts) ? cnt : '0;
        st_q   <= STW'(1);
        k_q    <= '0;
        j_q    <= '0;
      end
      if (state_q == ST_PAD) begin
        idx_q <= (CW'(idx_q) + CW'(1) == n_pts) ? '0 : idx_q + CNT_BITS'(1);
      end
      if (state_q == ST_WRB) begin
        if (j_q + CW'(1) != half) begin
          j_q <= j_q + CW'(1);
        end else begin
          j_q <= '0;
          if (k_q + m_pts >= n_pts) begin
            k_q  <= '0;
            st_q <= st_q + STW'(1);
          end else begin
            k_q <= k_q + m_pts;
          end
        end
      end
      if (out_load) idx_q <= (idx_q + CNT_BITS'(1) == cnt) ? '0 : idx_q + CNT_BITS'(1);
    end
  end

  // Work memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // Hold the upper operand while the lower one is read
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RDB) begin
      u_re_q <= rdata_q[2*VAL_BITS-1:VAL_BITS];
      u_im_q <= rdata_q[VAL_BITS-1:0];
    end
  end

  r2fft_bfly u_bfly (
    .clk_i   (clk_i),
    .ctl_i   (bctl),
    .u_re_i  (u_re_q),
    .u_im_i  (u_im_q),
    .b_re_i  (rdata_q[2*VAL_BITS-1:VAL_BITS]),
    .b_im_i  (rdata_q[VAL_BITS-1:0]),
    .w_re_i  (w_re),
    .w_im_i  (w_im),
    .s0_re_o (s0_re),
    .s0_im_o (s0_im),
    .s1_re_o (s1_re),
    .s1_im_o (s1_im)
  );

  // Output register: advance on load, drop valid when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_valid_q <= 1'b0;
    end else if (out_load) begin
      bin_valid_q <= 1'b1;
    end else if (!bin_stall_i) begin
      bin_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      bin_re_q <= rdata_q[2*VAL_BITS-1:VAL_BITS];
      bin_im_q <= rdata_q[VAL_BITS-1:0];
      last_q   <= (idx_q + CNT_BITS'(1) == cnt);
    end
  end

  assign sample_stall_o = (state_q != ST_LOAD);
  assign bin_valid_o    = bin_valid_q;
  assign bin_re_o       = bin_re_q;
  assign bin_im_o       = bin_im_q;
  assign last_bin_o     = last_q;

endmodule
